// ===== rtl/dinic_max_flow_engine_core_macros.svh =====
// ----------------------------------------------------------------------------
// dinic max flow engine assertion macros
// shared concurrent assertion forms, sampled on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef DINIC_MAX_FLOW_ENGINE_CORE_MACROS_SVH
`define DINIC_MAX_FLOW_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define DMF_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("dmf assertion failed");

// next-cycle implication
`define DMF_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dmf assertion failed");

`endif

// ===== rtl/dmf_pkg.sv =====
// ----------------------------------------------------------------------------
// dmf_pkg
// sizes, codes and shared types of the dinic max flow engine
// ----------------------------------------------------------------------------
package dmf_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_ARCS     = 1024;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int AIDX_W       = $clog2(MAX_ARCS);
    localparam int ARC_W        = AIDX_W + 1;
    localparam int CNT_W        = VIDX_W + 1;
    localparam int VCOUNT_W     = 7;
    localparam int CAP_W        = 32;
    localparam int FLOW_W       = CAP_W + 1;
    localparam int PUSH_W       = CAP_W + 1;
    localparam int TOTAL_W      = 43;
    localparam int ALU_W        = TOTAL_W + 1;

    localparam logic [ARC_W-1:0]  NIL_ARC   = ARC_W'(MAX_ARCS);
    localparam logic [PUSH_W-1:0] PUSH_ROOT = {1'b1, {CAP_W{1'b0}}};

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_RANGE     = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_SAME_ENDS = 2'd3;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // one dfs stack entry
    typedef struct packed {
        logic [VIDX_W-1:0] vertex;
        logic [AIDX_W-1:0] arc;
        logic [PUSH_W-1:0] push;
    } frame_t;

    // shared adder request and response
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] sum;
        logic             neg;
        logic             zero;
    } alu_rsp_t;

endpackage

// ===== rtl/dmf_ram.sv =====
// ----------------------------------------------------------------------------
// dmf_ram
// generic single write, single registered read memory
// ----------------------------------------------------------------------------
module dmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/dmf_alu.sv =====
// ----------------------------------------------------------------------------
// dmf_alu
// shared add, subtract and sign compare unit of the sequencer
// ----------------------------------------------------------------------------
module dmf_alu (
    input  dmf_pkg::alu_req_t req,
    output dmf_pkg::alu_rsp_t rsp
);
    import dmf_pkg::*;

    logic [ALU_W-1:0] result;

    // two's complement add or subtract
    assign result   = req.a + (req.sub ? ~req.b : req.b) + ALU_W'(req.sub);
    assign rsp.sum  = result;
    assign rsp.neg  = result[ALU_W-1];
    assign rsp.zero = (result == '0);

endmodule

// ===== rtl/dinic_max_flow_engine_core.sv =====
// ----------------------------------------------------------------------------
// dinic_max_flow_engine_core
// arc store with adjacency lists and a sequenced dinic max flow search
// ----------------------------------------------------------------------------
// channel   | handshake          | payload
// input     | start / busy       | operation, first_vertex, second_vertex, capacity
// result    | done strobe        | flow_value, status
// config    | cfg_we             | cfg_data (vertex count)
//
// for an add, done rises after ADD0 and ADD1 have written both arcs; for an
// error item done is registered at the accepting edge; an error item never raises busy.
// a query walks the arc list in the outflow sum and in every bfs phase, tries
// arcs in every dfs restart and updates both flows of each path arc at each
// push; the single read port of each arc memory and the shared adder pace that.
// reset clears list heads, arc count and flow state at once; no sweep.
// the receiver cannot stall: done is high for exactly one cycle.
// ----------------------------------------------------------------------------
`include "dinic_max_flow_engine_core_macros.svh"

module dinic_max_flow_engine_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [dmf_pkg::VIDX_W-1:0]    first_vertex,
    input  logic [dmf_pkg::VIDX_W-1:0]    second_vertex,
    input  logic [dmf_pkg::CAP_W-1:0]     capacity,
    output logic                          done,
    output logic signed [dmf_pkg::TOTAL_W-1:0] flow_value,
    output logic [1:0]                    status,
    input  logic                          cfg_we,
    input  logic [dmf_pkg::VCOUNT_W-1:0]  cfg_data
);
    import dmf_pkg::*;

    typedef enum logic [4:0] {
        IDLE, ADD0, ADD1,
        SUM_INIT, SUM_RD, SUM_ACC,
        BFS_INIT, BFS_POP, BFS_POP2, BFS_LIST, BFS_ARC, BFS_RES, BFS_END,
        DFS_INIT, DFS_INIT2, DFS_TOP, DFS_RES, DFS_CHK, DFS_POP, DFS_POP2, DFS_POP3,
        AUG_INIT, AUG_RD, AUG_ARC, AUG_F1, AUG_F2,
        FINISH
    } state_t;

    state_t                state_reg;
    logic [VCOUNT_W-1:0]   vcount_reg;
    logic [ARC_W-1:0]      arc_total_reg;
    logic [MAX_VERTICES-1:0] head_valid_reg;
    logic [MAX_VERTICES-1:0] level_valid_reg;
    logic                  done_reg;
    logic [TOTAL_W-1:0]    flow_value_reg;
    logic [1:0]            status_reg;
    logic [VIDX_W-1:0]     src_reg;
    logic [VIDX_W-1:0]     dst_reg;
    logic [CAP_W-1:0]      cap_reg;
    logic [TOTAL_W-1:0]    acc_reg;
    logic [ARC_W-1:0]      walk_reg;
    logic [AIDX_W-1:0]     tail_reg;
    logic [VIDX_W-1:0]     lvl_reg;
    logic [CNT_W-1:0]      rd_reg;
    logic [CNT_W-1:0]      wr_reg;
    logic [VIDX_W-1:0]     cur_v_reg;
    logic [PUSH_W-1:0]     push_reg;
    logic [CNT_W-1:0]      depth_reg;
    logic [CNT_W-1:0]      k_reg;
    logic [PUSH_W-1:0]     res_reg;
    logic                  res_pos_reg;
    logic [VIDX_W-1:0]     w_reg;
    logic [AIDX_W-1:0]     nxt_reg;
    logic [AIDX_W-1:0]     aug_arc_reg;

    // memory ports
    logic [AIDX_W-1:0] arc_raddr, flow_raddr, next_raddr, arc_waddr, flow_waddr, next_waddr;
    logic              arc_we, flow_we, next_we;
    logic [VIDX_W-1:0] ah_wdata, ah_rdata;
    logic [CAP_W-1:0]  cap_wdata, cap_rdata;
    logic [FLOW_W-1:0] flow_wdata, flow_rdata;
    logic [AIDX_W-1:0] next_wdata, next_rdata;
    logic [VIDX_W-1:0] lh_raddr, lt_raddr, lh_waddr, lt_waddr;
    logic              lh_we, lt_we;
    logic [AIDX_W-1:0] lh_wdata, lh_rdata, lt_wdata, lt_rdata;
    logic [VIDX_W-1:0] lvl_raddr, lvl_waddr, lvl_wdata, lvl_rdata;
    logic              lvl_we;
    logic [VIDX_W-1:0] q_raddr, q_waddr, q_wdata, q_rdata;
    logic              q_we;
    logic [VIDX_W-1:0] st_raddr, st_waddr;
    logic              st_we;
    frame_t            st_wdata, st_rdata;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;
    logic     alu_pos;

    logic [VCOUNT_W-1:0] live_n;
    logic                in_range;
    logic                store_full;
    logic [AIDX_W-1:0]   prev_tail;
    logic [ARC_W-1:0]    follow_walk;
    logic                dfs_take;
    logic [AIDX_W-1:0]   arc_lo;

    dmf_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_ARCS)) u_arc_head (
        .clk(clk), .we(arc_we), .waddr(arc_waddr), .wdata(ah_wdata),
        .raddr(arc_raddr), .rdata(ah_rdata));
    dmf_ram #(.WIDTH(CAP_W), .DEPTH(MAX_ARCS)) u_arc_cap (
        .clk(clk), .we(arc_we), .waddr(arc_waddr), .wdata(cap_wdata),
        .raddr(arc_raddr), .rdata(cap_rdata));
    dmf_ram #(.WIDTH(FLOW_W), .DEPTH(MAX_ARCS)) u_arc_flow (
        .clk(clk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
        .raddr(flow_raddr), .rdata(flow_rdata));
    dmf_ram #(.WIDTH(AIDX_W), .DEPTH(MAX_ARCS)) u_arc_next (
        .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(next_raddr), .rdata(next_rdata));
    dmf_ram #(.WIDTH(AIDX_W), .DEPTH(MAX_VERTICES)) u_list_head (
        .clk(clk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
        .raddr(lh_raddr), .rdata(lh_rdata));
    dmf_ram #(.WIDTH(AIDX_W), .DEPTH(MAX_VERTICES)) u_list_tail (
        .clk(clk), .we(lt_we), .waddr(lt_waddr), .wdata(lt_wdata),
        .raddr(lt_raddr), .rdata(lt_rdata));
    dmf_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_VERTICES)) u_level (
        .clk(clk), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
        .raddr(lvl_raddr), .rdata(lvl_rdata));
    dmf_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_VERTICES)) u_bfs_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata));
    dmf_ram #(.WIDTH($bits(frame_t)), .DEPTH(MAX_VERTICES)) u_dfs_stack (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata));

    dmf_alu u_alu (.req(alu_req), .rsp(alu_rsp));

    assign alu_pos = !alu_rsp.neg && !alu_rsp.zero;

    // input checks
    assign live_n     = (vcount_reg > VCOUNT_W'(MAX_VERTICES)) ? VCOUNT_W'(MAX_VERTICES)
                                                              : vcount_reg;
    assign in_range   = (VCOUNT_W'(first_vertex) < live_n) && (VCOUNT_W'(second_vertex) < live_n);
    assign store_full = ({1'b0, arc_total_reg} + (ARC_W + 1)'(2)) > (ARC_W + 1)'(MAX_ARCS);

    // list helpers
    assign arc_lo      = arc_total_reg[AIDX_W-1:0];
    assign prev_tail   = (src_reg == dst_reg) ? arc_lo : lt_rdata;
    assign follow_walk = (walk_reg[AIDX_W-1:0] == tail_reg) ? NIL_ARC : {1'b0, next_rdata};
    assign dfs_take    = res_pos_reg && level_valid_reg[w_reg]
                         && (CNT_W'(lvl_rdata) == CNT_W'(lvl_reg) + CNT_W'(1));

    // memory addressing and writes, adder operands
    always_comb
    begin
        arc_raddr  = walk_reg[AIDX_W-1:0];
        flow_raddr = walk_reg[AIDX_W-1:0];
        next_raddr = walk_reg[AIDX_W-1:0];
        arc_we = 1'b0;  arc_waddr = arc_lo;  ah_wdata = dst_reg;  cap_wdata = cap_reg;
        flow_we = 1'b0; flow_waddr = arc_lo; flow_wdata = '0;
        next_we = 1'b0; next_waddr = lt_rdata; next_wdata = arc_lo;
        lh_raddr = src_reg; lt_raddr = src_reg;
        lh_we = 1'b0; lh_waddr = src_reg; lh_wdata = arc_lo;
        lt_we = 1'b0; lt_waddr = src_reg; lt_wdata = arc_lo;
        lvl_raddr = w_reg; lvl_we = 1'b0; lvl_waddr = src_reg; lvl_wdata = '0;
        q_raddr = rd_reg[VIDX_W-1:0]; q_we = 1'b0; q_waddr = '0; q_wdata = src_reg;
        st_raddr = k_reg[VIDX_W-1:0]; st_we = 1'b0;
        st_waddr = VIDX_W'(depth_reg - 1'b1);
        st_wdata = '{vertex: cur_v_reg, arc: walk_reg[AIDX_W-1:0], push: push_reg};
        alu_req = '0;
        case (state_reg)
            IDLE:
            begin
                lh_raddr = first_vertex;
                lt_raddr = first_vertex;
            end
            ADD0:
            begin
                arc_we  = 1'b1;
                flow_we = 1'b1;
                if (head_valid_reg[src_reg])
                begin
                    next_we = 1'b1;
                end
                else
                begin
                    lh_we = 1'b1;
                end
                lt_we    = 1'b1;
                lt_raddr = dst_reg;
            end
            ADD1:
            begin
                arc_we     = 1'b1;
                arc_waddr  = arc_lo | AIDX_W'(1);
                ah_wdata   = src_reg;
                cap_wdata  = '0;
                flow_we    = 1'b1;
                flow_waddr = arc_lo | AIDX_W'(1);
                next_waddr = prev_tail;
                next_wdata = arc_lo | AIDX_W'(1);
                lh_waddr   = dst_reg;
                lh_wdata   = arc_lo | AIDX_W'(1);
                lt_waddr   = dst_reg;
                lt_wdata   = arc_lo | AIDX_W'(1);
                if (head_valid_reg[dst_reg])
                begin
                    next_we = 1'b1;
                end
                else
                begin
                    lh_we = 1'b1;
                end
                lt_we = 1'b1;
            end
            SUM_ACC:
            begin
                alu_req.a = ALU_W'(acc_reg);
                alu_req.b = {{(ALU_W - FLOW_W){flow_rdata[FLOW_W-1]}}, flow_rdata};
            end
            BFS_INIT:
            begin
                lvl_we = 1'b1;
                q_we   = 1'b1;
            end
            BFS_POP2:
            begin
                lh_raddr  = q_rdata;
                lt_raddr  = q_rdata;
                lvl_raddr = q_rdata;
            end
            BFS_RES:
            begin
                alu_req.a   = ALU_W'(cap_rdata);
                alu_req.b   = {{(ALU_W - FLOW_W){flow_rdata[FLOW_W-1]}}, flow_rdata};
                alu_req.sub = 1'b1;
                if (alu_pos && !level_valid_reg[ah_rdata])
                begin
                    lvl_we    = 1'b1;
                    lvl_waddr = ah_rdata;
                    lvl_wdata = lvl_reg + 1'b1;
                    q_we      = 1'b1;
                    q_waddr   = wr_reg[VIDX_W-1:0];
                    q_wdata   = ah_rdata;
                end
            end
            DFS_TOP:
            begin
                arc_raddr  = walk_reg[AIDX_W-1:0];
                flow_raddr = walk_reg[AIDX_W-1:0];
                next_raddr = walk_reg[AIDX_W-1:0];
            end
            DFS_RES:
            begin
                alu_req.a   = ALU_W'(cap_rdata);
                alu_req.b   = {{(ALU_W - FLOW_W){flow_rdata[FLOW_W-1]}}, flow_rdata};
                alu_req.sub = 1'b1;
                lvl_raddr   = ah_rdata;
                lh_raddr    = ah_rdata;
                lt_raddr    = ah_rdata;
            end
            DFS_CHK:
            begin
                alu_req.a   = ALU_W'(res_reg);
                alu_req.b   = ALU_W'(push_reg);
                alu_req.sub = 1'b1;
                st_we       = dfs_take;
            end
            DFS_POP:
            begin
                st_raddr = VIDX_W'(depth_reg - CNT_W'(2));
            end
            DFS_POP2:
            begin
                lt_raddr   = st_rdata.vertex;
                next_raddr = st_rdata.arc;
            end
            AUG_INIT:
            begin
                alu_req.a = ALU_W'(acc_reg);
                alu_req.b = ALU_W'(push_reg);
            end
            AUG_ARC:
            begin
                flow_raddr = st_rdata.arc;
            end
            AUG_F1:
            begin
                alu_req.a  = {{(ALU_W - FLOW_W){flow_rdata[FLOW_W-1]}}, flow_rdata};
                alu_req.b  = ALU_W'(push_reg);
                flow_we    = 1'b1;
                flow_waddr = aug_arc_reg;
                flow_wdata = alu_rsp.sum[FLOW_W-1:0];
                flow_raddr = aug_arc_reg ^ AIDX_W'(1);
            end
            AUG_F2:
            begin
                alu_req.a   = {{(ALU_W - FLOW_W){flow_rdata[FLOW_W-1]}}, flow_rdata};
                alu_req.b   = ALU_W'(push_reg);
                alu_req.sub = 1'b1;
                flow_we     = 1'b1;
                flow_waddr  = aug_arc_reg ^ AIDX_W'(1);
                flow_wdata  = alu_rsp.sum[FLOW_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VCOUNT_W'(MAX_VERTICES);
        end
        else if (cfg_we)
        begin
            vcount_reg <= cfg_data;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            arc_total_reg   <= '0;
            head_valid_reg  <= '0;
            level_valid_reg <= '0;
            done_reg        <= 1'b0;
            acc_reg         <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        src_reg        <= first_vertex;
                        dst_reg        <= second_vertex;
                        cap_reg        <= capacity;
                        flow_value_reg <= '0;
                        if (!in_range)
                        begin
                            status_reg <= STATUS_RANGE;
                            done_reg   <= 1'b1;
                        end
                        else if (operation == OP_ADD)
                        begin
                            if (store_full)
                            begin
                                status_reg <= STATUS_FULL;
                                done_reg   <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= ADD0;
                            end
                        end
                        else if (first_vertex == second_vertex)
                        begin
                            status_reg <= STATUS_SAME_ENDS;
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= SUM_INIT;
                        end
                    end
                end
                ADD0:
                begin
                    head_valid_reg[src_reg] <= 1'b1;
                    state_reg <= ADD1;
                end
                ADD1:
                begin
                    head_valid_reg[dst_reg] <= 1'b1;
                    arc_total_reg <= arc_total_reg + ARC_W'(2);
                    status_reg    <= STATUS_OK;
                    done_reg      <= 1'b1;
                    state_reg     <= IDLE;
                end
                // net outflow already on the source
                SUM_INIT:
                begin
                    acc_reg   <= '0;
                    walk_reg  <= head_valid_reg[src_reg] ? {1'b0, lh_rdata} : NIL_ARC;
                    tail_reg  <= lt_rdata;
                    state_reg <= SUM_RD;
                end
                SUM_RD:
                begin
                    state_reg <= (walk_reg == NIL_ARC) ? BFS_INIT : SUM_ACC;
                end
                SUM_ACC:
                begin
                    acc_reg   <= alu_rsp.sum[TOTAL_W-1:0];
                    walk_reg  <= follow_walk;
                    state_reg <= SUM_RD;
                end
                // level building
                BFS_INIT:
                begin
                    level_valid_reg <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << src_reg;
                    rd_reg    <= '0;
                    wr_reg    <= CNT_W'(1);
                    state_reg <= BFS_POP;
                end
                BFS_POP:
                begin
                    state_reg <= (rd_reg == wr_reg) ? BFS_END : BFS_POP2;
                end
                BFS_POP2:
                begin
                    rd_reg    <= rd_reg + 1'b1;
                    state_reg <= BFS_LIST;
                end
                BFS_LIST:
                begin
                    lvl_reg   <= lvl_rdata;
                    walk_reg  <= head_valid_reg[q_rdata] ? {1'b0, lh_rdata} : NIL_ARC;
                    tail_reg  <= lt_rdata;
                    state_reg <= BFS_ARC;
                end
                BFS_ARC:
                begin
                    state_reg <= (walk_reg == NIL_ARC) ? BFS_POP : BFS_RES;
                end
                BFS_RES:
                begin
                    if (alu_pos && !level_valid_reg[ah_rdata])
                    begin
                        level_valid_reg[ah_rdata] <= 1'b1;
                        wr_reg <= wr_reg + 1'b1;
                    end
                    walk_reg  <= follow_walk;
                    state_reg <= BFS_ARC;
                end
                BFS_END:
                begin
                    state_reg <= level_valid_reg[dst_reg] ? DFS_INIT : FINISH;
                end
                // one depth-first search from the source
                DFS_INIT:
                begin
                    state_reg <= DFS_INIT2;
                end
                DFS_INIT2:
                begin
                    cur_v_reg <= src_reg;
                    walk_reg  <= head_valid_reg[src_reg] ? {1'b0, lh_rdata} : NIL_ARC;
                    tail_reg  <= lt_rdata;
                    lvl_reg   <= '0;
                    push_reg  <= PUSH_ROOT;
                    depth_reg <= CNT_W'(1);
                    state_reg <= DFS_TOP;
                end
                DFS_TOP:
                begin
                    if (cur_v_reg == dst_reg)
                    begin
                        state_reg <= AUG_INIT;
                    end
                    else if (walk_reg == NIL_ARC)
                    begin
                        state_reg <= DFS_POP;
                    end
                    else
                    begin
                        state_reg <= DFS_RES;
                    end
                end
                DFS_RES:
                begin
                    res_reg     <= alu_rsp.sum[PUSH_W-1:0];
                    res_pos_reg <= alu_pos;
                    w_reg       <= ah_rdata;
                    nxt_reg     <= next_rdata;
                    state_reg   <= DFS_CHK;
                end
                DFS_CHK:
                begin
                    if (dfs_take)
                    begin
                        cur_v_reg <= w_reg;
                        walk_reg  <= head_valid_reg[w_reg] ? {1'b0, lh_rdata} : NIL_ARC;
                        tail_reg  <= lt_rdata;
                        lvl_reg   <= lvl_reg + 1'b1;
                        push_reg  <= alu_rsp.neg ? res_reg : push_reg;
                        depth_reg <= depth_reg + 1'b1;
                    end
                    else
                    begin
                        walk_reg <= (walk_reg[AIDX_W-1:0] == tail_reg) ? NIL_ARC
                                                                       : {1'b0, nxt_reg};
                    end
                    state_reg <= DFS_TOP;
                end
                DFS_POP:
                begin
                    if (depth_reg == CNT_W'(1))
                    begin
                        state_reg <= BFS_INIT;
                    end
                    else
                    begin
                        depth_reg <= depth_reg - 1'b1;
                        state_reg <= DFS_POP2;
                    end
                end
                DFS_POP2:
                begin
                    cur_v_reg <= st_rdata.vertex;
                    walk_reg  <= {1'b0, st_rdata.arc};
                    push_reg  <= st_rdata.push;
                    lvl_reg   <= lvl_reg - 1'b1;
                    state_reg <= DFS_POP3;
                end
                DFS_POP3:
                begin
                    tail_reg  <= lt_rdata;
                    walk_reg  <= (walk_reg[AIDX_W-1:0] == lt_rdata) ? NIL_ARC
                                                                    : {1'b0, next_rdata};
                    state_reg <= DFS_TOP;
                end
                // push the bottleneck along the stacked path
                AUG_INIT:
                begin
                    acc_reg   <= alu_rsp.sum[TOTAL_W-1:0];
                    k_reg     <= '0;
                    state_reg <= AUG_RD;
                end
                AUG_RD:
                begin
                    state_reg <= (k_reg == depth_reg - 1'b1) ? DFS_INIT : AUG_ARC;
                end
                AUG_ARC:
                begin
                    aug_arc_reg <= st_rdata.arc;
                    state_reg   <= AUG_F1;
                end
                AUG_F1:
                begin
                    state_reg <= AUG_F2;
                end
                AUG_F2:
                begin
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= AUG_RD;
                end
                FINISH:
                begin
                    flow_value_reg <= acc_reg;
                    status_reg     <= STATUS_OK;
                    done_reg       <= 1'b1;
                    state_reg      <= IDLE;
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != IDLE);
    assign done       = done_reg;
    assign flow_value = flow_value_reg;
    assign status     = status_reg;

    // checks
    `DMF_ASSERT_NOW(a_done_idle, done_reg, state_reg == IDLE)
    `DMF_ASSERT_NEXT(a_start_taken, start && !busy, busy || done)
    `DMF_ASSERT_NOW(a_arc_total_even, 1'b1, !arc_total_reg[0])
    `DMF_ASSERT_NOW(a_depth_nonzero, state_reg == DFS_TOP, depth_reg != '0)

endmodule

// ===== bench/dinic_max_flow_engine_core_checker.sv =====
// ----------------------------------------------------------------------------
// dinic max flow engine checker
// watches the item, result and config ports, keeps its own arc store and
// flow state, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module dinic_max_flow_engine_core_checker
    import dmf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic                      operation,
    input  logic [VIDX_W-1:0]         first_vertex,
    input  logic [VIDX_W-1:0]         second_vertex,
    input  logic [CAP_W-1:0]          capacity,
    input  logic                      done,
    input  logic signed [TOTAL_W-1:0] flow_value,
    input  logic [1:0]                status,
    input  logic                      cfg_we,
    input  logic [VCOUNT_W-1:0]       cfg_data,
    output int                        pending,
    output int                        fail_count
);

    localparam int NIL = MAX_ARCS;

    typedef struct {
        logic [TOTAL_W-1:0] flow;
        logic [1:0]         status;
    } flow_result_t;

    flow_result_t expected_results[$];

    // shadow arc store and search state
    int     tail_of[MAX_ARCS];
    int     head_of[MAX_ARCS];
    longint cap_of[MAX_ARCS];
    longint flow_of[MAX_ARCS];
    int     next_of[MAX_ARCS];
    int     first_arc[MAX_VERTICES];
    int     last_arc[MAX_VERTICES];
    int     arcs_used;
    int     level[MAX_VERTICES];
    int     bfs_fifo[MAX_VERTICES];
    int     stk_vertex[MAX_VERTICES+1];
    int     stk_arc[MAX_VERTICES+1];
    longint stk_push[MAX_VERTICES+1];
    logic [63:0] source_outflow;
    int     vertex_limit;

    function automatic int next_arc(int v, int a);
        if (a >= NIL || a == last_arc[v])
            return NIL;
        return next_of[a];
    endfunction

    function automatic void link_arc(int v, int a);
        if (first_arc[v] == NIL)
            first_arc[v] = a;
        else
            next_of[last_arc[v]] = a;
        last_arc[v] = a;
    endfunction

    // bfs over arcs with residual, true when sink gets a level
    function automatic bit levels_reach(int s, int t);
        int rd;
        int wr;
        int u;
        int a;
        int w;
        rd = 0;
        wr = 0;
        for (int i = 0; i < MAX_VERTICES; i++)
            level[i] = -1;
        level[s] = 0;
        bfs_fifo[wr++] = s;
        while (rd < wr) begin
            u = bfs_fifo[rd++];
            a = first_arc[u];
            while (a != NIL) begin
                w = head_of[a];
                if (cap_of[a] - flow_of[a] > 0 && level[w] == -1 && wr < MAX_VERTICES) begin
                    level[w] = level[tail_of[a]] + 1;
                    bfs_fifo[wr++] = w;
                end
                a = next_arc(u, a);
            end
        end
        return level[t] >= 0;
    endfunction

    // one dfs from the list heads, pushes the first path found
    function automatic longint push_one_path(int s, int t);
        int     depth;
        int     a;
        int     w;
        bit     found;
        longint res;
        longint b;
        depth = 1;
        stk_vertex[0] = s;
        stk_arc[0] = first_arc[s];
        stk_push[0] = longint'(1) << 62;
        while (depth > 0) begin
            found = 0;
            if (stk_push[depth-1] > 0 && stk_vertex[depth-1] == t) begin
                b = stk_push[depth-1];
                for (int k = 0; k + 1 < depth; k++) begin
                    flow_of[stk_arc[k]] += b;
                    flow_of[stk_arc[k] ^ 1] -= b;
                end
                return b;
            end
            while (stk_push[depth-1] > 0 && stk_arc[depth-1] != NIL) begin
                a = stk_arc[depth-1];
                res = cap_of[a] - flow_of[a];
                w = head_of[a];
                if (res > 0 && level[w] == level[stk_vertex[depth-1]] + 1
                    && depth < MAX_VERTICES + 1) begin
                    stk_vertex[depth] = w;
                    stk_arc[depth] = first_arc[w];
                    stk_push[depth] = (res < stk_push[depth-1]) ? res : stk_push[depth-1];
                    depth++;
                    found = 1;
                    break;
                end
                stk_arc[depth-1] = next_arc(stk_vertex[depth-1], a);
            end
            if (!found) begin
                depth--;
                if (depth > 0)
                    stk_arc[depth-1] = next_arc(stk_vertex[depth-1], stk_arc[depth-1]);
            end
        end
        return 0;
    endfunction

    function automatic flow_result_t predict_item(logic op, int u, int v, longint cap);
        flow_result_t r;
        int     n;
        int     a;
        longint x;
        r.flow = '0;
        r.status = STATUS_OK;
        n = (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : vertex_limit;
        if (u >= n || v >= n) begin
            r.status = STATUS_RANGE;
            return r;
        end
        if (op == OP_ADD) begin
            a = arcs_used;
            if (a + 2 > MAX_ARCS) begin
                r.status = STATUS_FULL;
                return r;
            end
            tail_of[a] = u;
            head_of[a] = v;
            cap_of[a] = cap;
            flow_of[a] = 0;
            tail_of[a+1] = v;
            head_of[a+1] = u;
            cap_of[a+1] = 0;
            flow_of[a+1] = 0;
            link_arc(u, a);
            link_arc(v, a + 1);
            arcs_used = a + 2;
            return r;
        end
        if (u == v) begin
            r.status = STATUS_SAME_ENDS;
            return r;
        end
        // start from present net outflow of the source
        source_outflow = '0;
        a = first_arc[u];
        while (a != NIL) begin
            source_outflow += 64'(flow_of[a]);
            a = next_arc(u, a);
        end
        while (levels_reach(u, v)) begin
            forever begin
                x = push_one_path(u, v);
                if (x == 0)
                    break;
                source_outflow += 64'(x);
            end
        end
        r.flow = source_outflow[TOTAL_W-1:0];
        return r;
    endfunction

    // compare results, then predict newly accepted items
    always @(posedge clk or negedge rst_n)
    begin
        flow_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                first_arc[i] = NIL;
                last_arc[i] = NIL;
                level[i] = -1;
            end
            arcs_used = 0;
            source_outflow = '0;
            vertex_limit = 64;
            expected_results.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: flow %0d status %0d",
                                 flow_value, status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (flow_value !== want.flow || status !== want.status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: flow exp %0d got %0d, status exp %0d got %0d",
                                     $signed(want.flow), flow_value, want.status, status);
                    end
                end
            end
            if (start && !busy)
                expected_results.insert(expected_results.size(),
                                        predict_item(operation, int'(first_vertex),
                                                     int'(second_vertex),
                                                     longint'(capacity)));
            if (cfg_we)
                vertex_limit = int'(cfg_data);
            pending = expected_results.size();
        end
    end

endmodule

// ===== bench/dinic_max_flow_engine_core_test.sv =====
// ----------------------------------------------------------------------------
// dinic max flow engine testbench
// directed add and query items over extremes and error cases, then random
// graphs under several vertex counts; a checker module predicts every result
// ----------------------------------------------------------------------------
module dinic_max_flow_engine_core_test;
    import dmf_pkg::*;

    localparam int CYCLE_LIMIT = 20000000;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      operation;
    logic [VIDX_W-1:0]         first_vertex;
    logic [VIDX_W-1:0]         second_vertex;
    logic [CAP_W-1:0]          capacity;
    logic                      done;
    logic signed [TOTAL_W-1:0] flow_value;
    logic [1:0]                status;
    logic                      cfg_we;
    logic [VCOUNT_W-1:0]       cfg_data;
    int                        pending;
    int                        fail_count;
    int                        cycle_count = 0;
    int                        live_count;
    bit                        gaps_on;

    dinic_max_flow_engine_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .first_vertex  (first_vertex),
        .second_vertex (second_vertex),
        .capacity      (capacity),
        .done          (done),
        .flow_value    (flow_value),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data)
    );

    dinic_max_flow_engine_core_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .first_vertex  (first_vertex),
        .second_vertex (second_vertex),
        .capacity      (capacity),
        .done          (done),
        .flow_value    (flow_value),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    // clock
    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // run length guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // present one item and hold it until the engine takes it
    task automatic send_item(logic op, int u, int v, logic [CAP_W-1:0] cap);
        start <= 1'b1;
        operation <= op;
        first_vertex <= VIDX_W'(u);
        second_vertex <= VIDX_W'(v);
        capacity <= cap;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // hold off until every expected result is back
    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic set_vertex_count(int value);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= VCOUNT_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        live_count = (value > MAX_VERTICES) ? MAX_VERTICES : value;
    endtask

    // vertex mostly within the live range, sometimes any 6-bit value
    function automatic int pick_vertex();
        if (live_count == 0 || $urandom_range(0, 9) == 0)
            return $urandom_range(0, 63);
        return $urandom_range(0, live_count - 1);
    endfunction

    function automatic logic [CAP_W-1:0] pick_capacity();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return $urandom_range(0, 20);
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 6)
                send_item(OP_ADD, pick_vertex(), pick_vertex(), pick_capacity());
            else
                send_item(OP_QUERY, pick_vertex(), pick_vertex(), $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_ADD;
        first_vertex = '0;
        second_vertex = '0;
        capacity = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        live_count = 64;
        gaps_on = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, self loop, zero capacity, persistence, errors
        send_item(OP_ADD, 0, 1, 32'hFFFF_FFFF);
        send_item(OP_ADD, 1, 2, 32'd5);
        send_item(OP_ADD, 0, 2, 32'd0);
        send_item(OP_ADD, 2, 2, 32'd7);
        send_item(OP_ADD, 63, 0, 32'd1);
        send_item(OP_ADD, 1, 63, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 0, 2, 32'hFFFF_FFFF);
        send_item(OP_QUERY, 0, 2, 32'd0);
        send_item(OP_QUERY, 2, 0, 32'd0);
        send_item(OP_QUERY, 5, 5, 32'd0);
        send_item(OP_QUERY, 0, 63, 32'd0);
        set_vertex_count(3);
        send_item(OP_ADD, 3, 0, 32'd1);
        send_item(OP_QUERY, 0, 63, 32'd0);
        send_item(OP_QUERY, 0, 1, 32'd0);
        set_vertex_count(0);
        send_item(OP_ADD, 0, 0, 32'd1);
        send_item(OP_QUERY, 0, 1, 32'd0);
        set_vertex_count(1);
        send_item(OP_QUERY, 0, 0, 32'd0);
        send_item(OP_ADD, 0, 0, 32'hAAAA_5555);
        set_vertex_count(127);
        send_item(OP_ADD, 62, 63, 32'hFFFF_FFFF);
        send_item(OP_ADD, 63, 62, 32'h5555_AAAA);
        send_item(OP_QUERY, 63, 0, 32'd0);
        send_item(OP_QUERY, 62, 63, 32'd0);

        // random graphs under several vertex counts
        set_vertex_count($urandom_range(2, 8));
        random_phase(20);
        set_vertex_count($urandom_range(2, 8));
        random_phase(20);
        set_vertex_count(64);
        random_phase(15);
        set_vertex_count($urandom_range(2, 6));
        random_phase(10);
        drain_results();
        gaps_on = 1'b0;
        random_phase(10);

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
